### design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication shorthand on the same clocking.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	`ASSERT_CLKD(label, clk, rst_n, (cond) |-> (prop), msg)

`endif

### design/hmgm_pkg.sv
package hmgm_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int INDEX_BITS  = 24;
	localparam int ENTRY_BITS  = INDEX_BITS + 1;
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
	localparam int DIM_BITS    = 13;
	localparam int SCALE_BITS  = 16;
	localparam int HEIGHT_BITS = 32;
	localparam int COORD_BITS  = 48;
	localparam int FRAC_SHIFT  = 8;

	// Configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_X_SCALE      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Y_SCALE      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Z_SCALE      = 3'd4;

	// Window corner validity codes: bit0 upper-left, bit1 upper, bit2 left, bit3 current
	localparam logic [3:0] WIN_ALL       = 4'd15;
	localparam logic [3:0] WIN_NO_UPLEFT = 4'd14;
	localparam logic [3:0] WIN_NO_UPPER  = 4'd13;
	localparam logic [3:0] WIN_NO_LEFT   = 4'd11;
	localparam logic [3:0] WIN_NO_CUR    = 4'd7;

	// Result queue
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [ENTRY_BITS-1:0] entry_t;

	typedef struct packed {
		index_t a;
		index_t b;
		index_t c;
	} tri_t;

	// All results caused by one sample
	typedef struct packed {
		logic                          has_vtx;
		logic [1:0]                    ntri;
		index_t                        vidx;
		logic signed [COORD_BITS-1:0]  cx;
		logic signed [COORD_BITS-1:0]  cy;
		logic signed [COORD_BITS-1:0]  cz;
		tri_t                          t0;
		tri_t                          t1;
	} record_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} front_status_t;

endpackage

### design/hmgm_cfg_if.sv
interface hmgm_cfg_if import hmgm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/hmgm_sample_if.sv
interface hmgm_sample_if import hmgm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [HEIGHT_BITS-1:0] height_sample;
	logic                          sample_valid;

	modport source (output valid, output height_sample, output sample_valid, input ready);
	modport sink (input valid, input height_sample, input sample_valid, output ready);
endinterface

### design/hmgm_result_if.sv
interface hmgm_result_if import hmgm_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [INDEX_BITS-1:0]        index_a;
	logic [INDEX_BITS-1:0]        index_b;
	logic [INDEX_BITS-1:0]        index_c;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;
	logic                         run_last;

	modport source (output valid, output kind, output index_a, output index_b,
		output index_c, output coord_x, output coord_y, output coord_z,
		output run_last, input ready);
	modport sink (input valid, input kind, input index_a, input index_b,
		input index_c, input coord_x, input coord_y, input coord_z,
		input run_last, output ready);
endinterface

### design/hmgm_line_store.sv
module hmgm_line_store import hmgm_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [COL_BITS-1:0] waddr,
	input  entry_t              wdata,
	input  logic                re,
	input  logic [COL_BITS-1:0] raddr,
	output entry_t              rdata
);

	entry_t mem [MAX_WIDTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/hmgm_mesh_front.sv
module hmgm_mesh_front import hmgm_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [HEIGHT_BITS-1:0] height_sample,
	input  logic                          sample_valid,
	input  logic [DIM_BITS-1:0]           dim_w,
	input  logic [DIM_BITS-1:0]           dim_h,
	input  logic signed [SCALE_BITS-1:0]  x_scale,
	input  logic signed [SCALE_BITS-1:0]  y_scale,
	input  logic signed [SCALE_BITS-1:0]  z_scale,
	output front_status_t                 status,
	output logic                          push,
	output record_t                       push_rec
);

	// Position and index state
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	index_t              nv_q;
	entry_t              left_q;
	entry_t              upleft_q;

	// Stage 1: line store read in flight
	logic                          v_s1;
	logic [COL_BITS-1:0]           col_s1;
	logic [ROW_BITS-1:0]           row_s1;
	logic signed [HEIGHT_BITS-1:0] height_s1;
	entry_t                        cur_s1;
	entry_t                        left_s1;
	logic                          win_s1;

	// Stage 2: finished record
	logic    v_s2;
	record_t rec_s2;

	entry_t upper;

	// Position of the current sample, with wrap if dimensions shrank
	logic                wrap_c, wrap_r, end_row, end_frame;
	logic [ROW_BITS:0]   row_pre, row_inc;
	logic [COL_BITS:0]   col_inc;
	logic [COL_BITS-1:0] col0;
	logic [ROW_BITS-1:0] row0;
	index_t              nv0, nv_inc;
	entry_t              cur;

	always_comb begin
		wrap_c  = {1'b0, col_q} >= dim_w;
		col0    = wrap_c ? '0 : col_q;
		row_pre = wrap_c ? {1'b0, row_q} + 1'b1 : {1'b0, row_q};
		wrap_r  = row_pre >= dim_h;
		row0    = wrap_r ? '0 : row_pre[ROW_BITS-1:0];
		nv0     = wrap_r ? '0 : nv_q;
		cur     = sample_valid ? {1'b1, nv0} : '0;
		nv_inc  = nv0 + index_t'(sample_valid);
		col_inc = {1'b0, col0} + 1'b1;
		row_inc = {1'b0, row0} + 1'b1;
		end_row   = col_inc >= dim_w;
		end_frame = end_row && (row_inc >= dim_h);
	end

	// Counter update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			nv_q   <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
				row_q <= row0;
			end
			nv_q <= end_frame ? '0 : nv_inc;
		end
	end

	// Left neighbor: only read when the next sample sits in the same row
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= cur;
		end
	end

	hmgm_line_store u_store (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (cur_s1),
		.re    (accept),
		.raddr (col0),
		.rdata (upper)
	);

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col0;
			row_s1    <= row0;
			height_s1 <= height_sample;
			cur_s1    <= cur;
			left_s1   <= left_q;
			win_s1    <= (col0 != '0) && (row0 != '0);
		end
		// Upper entry of this sample is the upper-left of the next one
		if (v_s1) begin
			upleft_q <= upper;
		end
	end

	// Coordinates: one multiplier per axis
	logic signed [SCALE_BITS+COL_BITS:0]      x_prod;
	logic signed [SCALE_BITS+ROW_BITS+1:0]    y_prod;
	logic signed [SCALE_BITS:0]               y_neg;
	logic signed [SCALE_BITS+HEIGHT_BITS-1:0] z_prod;

	always_comb begin
		x_prod = x_scale * $signed({1'b0, col_s1});
		y_neg  = -$signed({y_scale[SCALE_BITS-1], y_scale});
		y_prod = y_neg * $signed({1'b0, row_s1});
	end
	assign z_prod = z_scale * height_s1;

	// Triangle selection from corner validity
	logic [3:0] code;
	logic [1:0] ntri;
	tri_t       t0, t1;
	index_t     i1, i2, i3, i4;

	always_comb begin
		i1   = upleft_q[INDEX_BITS-1:0];
		i2   = upper[INDEX_BITS-1:0];
		i3   = left_s1[INDEX_BITS-1:0];
		i4   = cur_s1[INDEX_BITS-1:0];
		code = win_s1 ? {cur_s1[INDEX_BITS], left_s1[INDEX_BITS],
			upper[INDEX_BITS], upleft_q[INDEX_BITS]} : 4'd0;
		ntri = 2'd0;
		t0   = '{a: i1, b: i3, c: i2};
		t1   = '{a: i3, b: i4, c: i2};
		unique case (code)
			WIN_ALL: begin
				ntri = 2'd2;
			end
			WIN_NO_UPLEFT: begin
				ntri = 2'd1;
				t0   = '{a: i3, b: i4, c: i2};
			end
			WIN_NO_UPPER: begin
				ntri = 2'd1;
				t0   = '{a: i1, b: i3, c: i4};
			end
			WIN_NO_LEFT: begin
				ntri = 2'd1;
				t0   = '{a: i1, b: i4, c: i2};
			end
			WIN_NO_CUR: begin
				ntri = 2'd1;
			end
			default: begin
				ntri = 2'd0;
			end
		endcase
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			rec_s2.has_vtx <= cur_s1[INDEX_BITS];
			rec_s2.ntri    <= ntri;
			rec_s2.vidx    <= i4;
			rec_s2.cx      <= COORD_BITS'($signed({x_prod, {FRAC_SHIFT{1'b0}}}));
			rec_s2.cy      <= COORD_BITS'($signed({y_prod, {FRAC_SHIFT{1'b0}}}));
			rec_s2.cz      <= COORD_BITS'(z_prod >>> FRAC_SHIFT);
			rec_s2.t0      <= t0;
			rec_s2.t1      <= t1;
		end
	end

	assign status   = '{v_s1: v_s1, v_s2: v_s2};
	assign push     = v_s2 && (rec_s2.has_vtx || (rec_s2.ntri != 2'd0));
	assign push_rec = rec_s2;

endmodule

### design/hmgm_result_queue.sv
module hmgm_result_queue import hmgm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  record_t               push_rec,
	output logic [QCNT_BITS-1:0]  count,
	hmgm_result_if.source         results
);

	record_t              q_mem [QDEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic [1:0]           phase_q;

	record_t    head;
	logic [1:0] nres, tri_sel;
	logic       vtx_now, last, pop;
	tri_t       tsel;

	always_comb begin
		head    = q_mem[rptr_q];
		nres    = {1'b0, head.has_vtx} + head.ntri;
		vtx_now = head.has_vtx && (phase_q == 2'd0);
		tri_sel = head.has_vtx ? phase_q - 2'd1 : phase_q;
		tsel    = (tri_sel == 2'd0) ? head.t0 : head.t1;
		last    = phase_q == (nres - 2'd1);
		pop     = results.valid && results.ready && last;
	end

	// Storage writes
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= push_rec;
		end
	end

	// Pointers, fill count and result phase within the head record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			phase_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q  <= rptr_q + 1'b1;
				phase_q <= '0;
			end else if (results.valid && results.ready) begin
				phase_q <= phase_q + 2'd1;
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	assign count            = count_q;
	assign results.valid    = count_q != '0;
	assign results.kind     = !vtx_now;
	assign results.index_a  = vtx_now ? head.vidx : tsel.a;
	assign results.index_b  = vtx_now ? '0 : tsel.b;
	assign results.index_c  = vtx_now ? '0 : tsel.c;
	assign results.coord_x  = vtx_now ? head.cx : '0;
	assign results.coord_y  = vtx_now ? head.cy : '0;
	assign results.coord_z  = vtx_now ? head.cz : '0;
	assign results.run_last = last;

endmodule

### design/height_map_grid_mesh_builder_unit.sv
// Height-map mesh builder. Samples arrive in raster order on the samples channel;
// every valid sample yields a vertex item, and each 2x2 window ending at the sample
// yields up to two triangle items, all on the one results channel (vertex first,
// run_last on the final item of a sample). A new sample is taken every cycle while
// the four-record result queue has room; since the results channel moves one item
// per cycle while results.ready is high, maps dense in vertices and triangles are
// paced by the results channel and sparse ones run faster. The first result item of
// a sample is offered once it has passed stage 1, stage 2 and the result queue. The
// previous row lives in a 4096-entry line store read when a sample is taken and
// written back in the next cycle. Configuration is written through cfg, which is
// always ready; the user must do so only while no sample is in work (not enforced).
module height_map_grid_mesh_builder_unit import hmgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	hmgm_cfg_if.sink      cfg,
	hmgm_sample_if.sink   samples,
	hmgm_result_if.source results
);

	logic [DIM_BITS-1:0]          width_q, height_q;
	logic signed [SCALE_BITS-1:0] xs_q, ys_q, zs_q;
	logic [DIM_BITS-1:0]          dim_w, dim_h;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(640);
			height_q <= DIM_BITS'(480);
			xs_q     <= SCALE_BITS'(256);
			ys_q     <= SCALE_BITS'(256);
			zs_q     <= SCALE_BITS'(256);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[DIM_BITS-1:0];
				REG_X_SCALE:      xs_q     <= cfg.data;
				REG_Y_SCALE:      ys_q     <= cfg.data;
				REG_Z_SCALE:      zs_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Clamp dimensions to the supported range
	always_comb begin
		dim_w = (width_q < DIM_BITS'(2)) ? DIM_BITS'(2)
			: (width_q > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_q;
		dim_h = (height_q < DIM_BITS'(2)) ? DIM_BITS'(2)
			: (height_q > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_q;
	end

	front_status_t        status;
	logic                 push;
	record_t              push_rec;
	logic [QCNT_BITS-1:0] q_count;
	logic [QCNT_BITS:0]   pending;
	logic                 accept;

	// Room check covers records still in the two pipeline stages
	assign pending = {1'b0, q_count} + (QCNT_BITS+1)'(status.v_s1)
		+ (QCNT_BITS+1)'(status.v_s2);
	assign samples.ready = pending < (QCNT_BITS+1)'(QDEPTH);
	assign accept = samples.valid && samples.ready;

	hmgm_mesh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.height_sample (samples.height_sample),
		.sample_valid  (samples.sample_valid),
		.dim_w         (dim_w),
		.dim_h         (dim_h),
		.x_scale       (xs_q),
		.y_scale       (ys_q),
		.z_scale       (zs_q),
		.status        (status),
		.push          (push),
		.push_rec      (push_rec)
	);

	hmgm_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.count    (q_count),
		.results  (results)
	);

endmodule

### design/hmgm_checker.sv
`include "assert_macros.svh"

module hmgm_checker import hmgm_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_kind,
	input logic [INDEX_BITS-1:0]        res_index_a,
	input logic [INDEX_BITS-1:0]        res_index_b,
	input logic [INDEX_BITS-1:0]        res_index_c,
	input logic signed [COORD_BITS-1:0] res_coord_x,
	input logic signed [COORD_BITS-1:0] res_coord_y,
	input logic signed [COORD_BITS-1:0] res_coord_z,
	input logic                         res_run_last
);

	// Triangle items carry no position
	`ASSERT_IMPL(a_tri_no_coord, clk, arst_n, res_valid && res_kind, (res_coord_x == '0) && (res_coord_y == '0) && (res_coord_z == '0), "triangle item with nonzero coordinates")

	// Vertex items carry no second or third corner
	`ASSERT_IMPL(a_vtx_no_corners, clk, arst_n, res_valid && !res_kind, (res_index_b == '0) && (res_index_c == '0), "vertex item with corner indices")

	// A vertex item that is not last is followed by a triangle of the same sample
	`ASSERT_CLKD(a_vtx_then_tri, clk, arst_n, (res_valid && res_ready && !res_kind && !res_run_last) |=> (res_valid && res_kind), "vertex item not followed by its triangle")

	// A stalled item holds
	`ASSERT_CLKD(a_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(res_index_a) && $stable(res_kind) && $stable(res_run_last)), "stalled result item changed")

endmodule

bind height_map_grid_mesh_builder_unit hmgm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.res_kind     (results.kind),
	.res_index_a  (results.index_a),
	.res_index_b  (results.index_b),
	.res_index_c  (results.index_c),
	.res_coord_x  (results.coord_x),
	.res_coord_y  (results.coord_y),
	.res_coord_z  (results.coord_z),
	.res_run_last (results.run_last)
);
